// ===== hw/rtl/sbmq_pkg.sv =====
package sbmq_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int NUM_QUEUES_DEF = 4;
   localparam int QNUM_W = 2;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;
   localparam int QCOUNT_W = 9;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_FETCH
   } state_type;

endpackage

// ===== hw/rtl/sbmq_if.sv =====
interface sbmq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [sbmq_pkg::QNUM_W-1:0]         queue_number;
   logic signed [sbmq_pkg::DATA_W-1:0]  value;

   modport source (output valid, output opcode, output queue_number, output value,
                   input ready);
   modport sink (input valid, input opcode, input queue_number, input value,
                 output ready);
endinterface

interface sbmq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sbmq_pkg::DATA_W-1:0]  dequeued_value;
   logic [sbmq_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output dequeued_value, output status, input ready);
   modport sink (input valid, input dequeued_value, input status, output ready);
endinterface

// ===== hw/rtl/sbmq_ram.sv =====
module sbmq_ram #(
   parameter int DEPTH = sbmq_pkg::SLOT_COUNT_DEF,
   parameter int WIDTH = sbmq_pkg::DATA_W,
   parameter int ADDR_W = $clog2(sbmq_pkg::SLOT_COUNT_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/shared_buffer_multi_queue_top.sv =====
// Results: an enqueue or a failed dequeue is answered from the lookup state, a successful
// dequeue from the fetch state after it; both wait while an earlier result is still held.
// Throughput: one operation at a time, as a new request is taken only back in the idle
// state, a pace set by the registered reads of the queue-pointer and link memories.
// Reset is synchronous and active high; it clears the control state and empties every
// queue at once, with no clearing pass, because untouched slots are tracked by a fill pointer.
module shared_buffer_multi_queue_top #(
   parameter int SLOT_COUNT = sbmq_pkg::SLOT_COUNT_DEF,
   parameter int NUM_QUEUES = sbmq_pkg::NUM_QUEUES_DEF
) (
   input logic         clock,
   input logic         reset,
   sbmq_req_if.sink    req_ch,
   sbmq_rsp_if.source  rsp_ch
);

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int DW = sbmq_pkg::DATA_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SLOT_COUNT);
   localparam logic [sbmq_pkg::QCOUNT_W-1:0] QUEUE_LIMIT =
      sbmq_pkg::QCOUNT_W'(NUM_QUEUES);

   sbmq_pkg::state_type   state_ff, state_in;
   sbmq_pkg::opcode_type  op_ff, op_in;
   logic                  q_ok_ff, q_ok_in;
   logic [QW-1:0]         q_idx_ff, q_idx_in;
   logic [DW-1:0]         val_ff, val_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [AW-1:0]         free_head_ff, free_head_in;
   logic [CW-1:0]         free_count_ff, free_count_in;
   logic [CW-1:0]         fresh_ff, fresh_in;
   logic [NUM_QUEUES-1:0] qempty_ff, qempty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]         rsp_data_ff, rsp_data_in;
   sbmq_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  out_free;
   logic                  q_in_range;
   logic [QW+1:0]         q_wide;
   logic                  q_empty_sel;
   logic                  slot_fresh;
   logic [AW-1:0]         next_free;

   logic                  qm_wr_en;
   logic [QW-1:0]         qm_wr_addr;
   logic [2*AW-1:0]       qm_wr_data;
   logic [2*AW-1:0]       qm_rd_data;
   logic [AW-1:0]         q_head_rd, q_tail_rd;

   logic                  lk_wr_en;
   logic [AW-1:0]         lk_wr_addr;
   logic [AW-1:0]         lk_wr_data;
   logic                  lk_rd_en;
   logic [AW-1:0]         lk_rd_addr;
   logic [AW-1:0]         lk_rd_data;

   logic                  dt_wr_en;
   logic                  dt_rd_en;
   logic [DW-1:0]         dt_rd_data;

   assign req_ch.ready = (state_ff == sbmq_pkg::S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign q_wide = {{QW{1'b0}}, req_ch.queue_number};
   assign q_in_range = {{(sbmq_pkg::QCOUNT_W - sbmq_pkg::QNUM_W){1'b0}},
                        req_ch.queue_number} < QUEUE_LIMIT;
   assign q_empty_sel = qempty_ff[q_idx_ff];

   assign q_head_rd = qm_rd_data[2*AW-1:AW];
   assign q_tail_rd = qm_rd_data[AW-1:0];

   // Slots at or above the fill pointer were never handed out and still link upward.
   assign slot_fresh = CW'(free_head_ff) >= fresh_ff;
   assign next_free = !slot_fresh ? lk_rd_data :
                      (free_head_ff == LAST_SLOT) ? '0 : free_head_ff + AW'(1);

   assign lk_rd_addr = (state_ff == sbmq_pkg::S_IDLE) ? free_head_ff : q_head_rd;

   sbmq_ram #(.DEPTH(NUM_QUEUES), .WIDTH(2 * AW), .ADDR_W(QW)) u_queue_ram (
      .clock   (clock),
      .wr_en   (qm_wr_en),
      .wr_addr (qm_wr_addr),
      .wr_data (qm_wr_data),
      .rd_en   (accept),
      .rd_addr (q_wide[QW-1:0]),
      .rd_data (qm_rd_data)
   );

   sbmq_ram #(.DEPTH(SLOT_COUNT), .WIDTH(AW), .ADDR_W(AW)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_wr_en),
      .wr_addr (lk_wr_addr),
      .wr_data (lk_wr_data),
      .rd_en   (lk_rd_en),
      .rd_addr (lk_rd_addr),
      .rd_data (lk_rd_data)
   );

   sbmq_ram #(.DEPTH(SLOT_COUNT), .WIDTH(DW), .ADDR_W(AW)) u_data_ram (
      .clock   (clock),
      .wr_en   (dt_wr_en),
      .wr_addr (free_head_ff),
      .wr_data (val_ff),
      .rd_en   (dt_rd_en),
      .rd_addr (q_head_rd),
      .rd_data (dt_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      q_ok_in = q_ok_ff;
      q_idx_in = q_idx_ff;
      val_in = val_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      free_head_in = free_head_ff;
      free_count_in = free_count_ff;
      fresh_in = fresh_ff;
      qempty_in = qempty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      qm_wr_en = 1'b0;
      qm_wr_addr = q_idx_ff;
      qm_wr_data = {q_head_rd, free_head_ff};
      lk_wr_en = 1'b0;
      lk_wr_addr = q_tail_rd;
      lk_wr_data = free_head_ff;
      lk_rd_en = accept;
      dt_wr_en = 1'b0;
      dt_rd_en = 1'b0;

      case (state_ff)
         sbmq_pkg::S_IDLE: begin
            if (accept) begin
               op_in = sbmq_pkg::opcode_type'(req_ch.opcode);
               q_ok_in = q_in_range;
               q_idx_in = q_wide[QW-1:0];
               val_in = req_ch.value;
               state_in = sbmq_pkg::S_LOOK;
            end
         end
         sbmq_pkg::S_LOOK: begin
            if (op_ff == sbmq_pkg::OP_ENQ) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '0;
                  state_in = sbmq_pkg::S_IDLE;
                  if (!q_ok_ff || free_count_ff == '0) begin
                     rsp_status_in = sbmq_pkg::ST_FULL;
                  end else begin
                     rsp_status_in = sbmq_pkg::ST_OK;
                     dt_wr_en = 1'b1;
                     qm_wr_en = 1'b1;
                     if (q_empty_sel) begin
                        qm_wr_data = {free_head_ff, free_head_ff};
                        qempty_in[q_idx_ff] = 1'b0;
                     end else begin
                        lk_wr_en = 1'b1;
                     end
                     if (slot_fresh) begin
                        fresh_in = fresh_ff + CW'(1);
                     end
                     free_head_in = next_free;
                     free_count_in = free_count_ff - CW'(1);
                  end
               end
            end else if (!q_ok_ff || q_empty_sel) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '0;
                  rsp_status_in = sbmq_pkg::ST_EMPTY;
                  state_in = sbmq_pkg::S_IDLE;
               end
            end else begin
               lk_rd_en = 1'b1;
               dt_rd_en = 1'b1;
               head_in = q_head_rd;
               tail_in = q_tail_rd;
               state_in = sbmq_pkg::S_FETCH;
            end
         end
         sbmq_pkg::S_FETCH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = dt_rd_data;
               rsp_status_in = sbmq_pkg::ST_OK;
               if (head_ff == tail_ff) begin
                  qempty_in[q_idx_ff] = 1'b1;
               end else begin
                  qm_wr_en = 1'b1;
                  qm_wr_data = {lk_rd_data, tail_ff};
               end
               lk_wr_en = 1'b1;
               lk_wr_addr = head_ff;
               free_head_in = head_ff;
               if (free_count_ff < FULL_COUNT) begin
                  free_count_in = free_count_ff + CW'(1);
               end
               state_in = sbmq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sbmq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbmq_pkg::S_IDLE;
         free_head_ff <= '0;
         free_count_ff <= FULL_COUNT;
         fresh_ff <= '0;
         qempty_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_head_ff <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff <= fresh_in;
         qempty_ff <= qempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      q_ok_ff <= q_ok_in;
      q_idx_ff <= q_idx_in;
      val_ff <= val_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.dequeued_value = rsp_data_ff;
   assign rsp_ch.status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FULL_COUNT)
      else $error("free slot count exceeds the store size");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= FULL_COUNT)
      else $error("fill pointer runs past the store");

   a_enq_has_slot: assert property (@(posedge clock) disable iff (reset)
      dt_wr_en |-> free_count_ff != '0)
      else $error("enqueue writes a slot while none is free");

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sbmq_pkg::S_LOOK)
      else $error("accepted transfer did not start a lookup");

   a_fetch_is_deq: assert property (@(posedge clock) disable iff (reset)
      state_ff == sbmq_pkg::S_FETCH |-> op_ff == sbmq_pkg::OP_DEQ)
      else $error("slot fetch entered for an enqueue");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_W = $clog2(sbmq_pkg::SLOT_COUNT_DEF);
   localparam int CALM_TAIL = 80;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      sbmq_pkg::opcode_type                op;
      logic [sbmq_pkg::QNUM_W-1:0]         qn;
      logic signed [sbmq_pkg::DATA_W-1:0]  val;
   } op_item_type;

   typedef struct packed {
      logic signed [sbmq_pkg::DATA_W-1:0]  word;
      sbmq_pkg::status_type                st;
   } outcome_type;

   logic clock;
   logic reset;

   sbmq_req_if req_ch();
   sbmq_rsp_if rsp_ch();

   shared_buffer_multi_queue_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the slot store, the free list and the queue pointers.
   logic [sbmq_pkg::DATA_W-1:0] slot_word [sbmq_pkg::SLOT_COUNT_DEF];
   logic [SLOT_W-1:0] slot_next [sbmq_pkg::SLOT_COUNT_DEF];
   logic [SLOT_W-1:0] spare_head;
   int                spare_cnt;
   logic [SLOT_W-1:0] q_first [sbmq_pkg::NUM_QUEUES_DEF];
   logic [SLOT_W-1:0] q_last [sbmq_pkg::NUM_QUEUES_DEF];
   logic              q_vacant [sbmq_pkg::NUM_QUEUES_DEF];

   op_item_type op_backlog[$];
   outcome_type due_outcomes[$];
   op_item_type next_op;

   int   total_items;
   int   took_cnt;
   int   got_cnt;
   int   mismatch_cnt;
   logic req_took;
   logic idle_on;
   int   send_gap;
   int   hold_left;
   logic long_hold_done;

   assign idle_on = (took_cnt < total_items - CALM_TAIL) && ((took_cnt / 40) % 4 != 3);

   function automatic outcome_type queue_store_step(op_item_type it);
      outcome_type res;
      logic [SLOT_W-1:0] s;
      res.word = '0;
      res.st = sbmq_pkg::ST_OK;
      if (it.op == sbmq_pkg::OP_ENQ) begin
         if (spare_cnt == 0) begin
            res.st = sbmq_pkg::ST_FULL;
         end else begin
            s = spare_head;
            spare_head = slot_next[s];
            slot_word[s] = it.val;
            slot_next[s] = s;
            if (q_vacant[it.qn]) begin
               q_first[it.qn] = s;
               q_vacant[it.qn] = 1'b0;
            end else begin
               slot_next[q_last[it.qn]] = s;
            end
            q_last[it.qn] = s;
            spare_cnt--;
         end
      end else begin
         if (q_vacant[it.qn]) begin
            res.st = sbmq_pkg::ST_EMPTY;
         end else begin
            s = q_first[it.qn];
            res.word = slot_word[s];
            if (s == q_last[it.qn]) begin
               q_vacant[it.qn] = 1'b1;
            end else begin
               q_first[it.qn] = slot_next[s];
            end
            slot_next[s] = spare_head;
            spare_head = s;
            spare_cnt++;
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_cnt++;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = 1'b0;
      req_ch.queue_number = '0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      fork
         forever #10 clock = ~clock;
         begin
            repeat (8) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   initial begin
      op_item_type it;
      int enq_pct;
      logic signed [sbmq_pkg::DATA_W-1:0] edge_vals [4];
      edge_vals[0] = 32'sh7fffffff;
      edge_vals[1] = 32'sh80000000;
      edge_vals[2] = 32'sh00000000;
      edge_vals[3] = -32'sd1;

      // Dequeue from empty queues, fill the whole store, overflow, then drain a few.
      it = '{sbmq_pkg::OP_DEQ, 2'd0, 32'sh7fffffff};
      op_backlog.push_back(it);
      it = '{sbmq_pkg::OP_DEQ, 2'd3, -32'sd1};
      op_backlog.push_back(it);
      for (int i = 0; i < sbmq_pkg::SLOT_COUNT_DEF; i++) begin
         it.op = sbmq_pkg::OP_ENQ;
         it.qn = sbmq_pkg::QNUM_W'(i % sbmq_pkg::NUM_QUEUES_DEF);
         it.val = (i < 4) ? edge_vals[i] : (i % 2 ? 32'shaaaaaaaa : 32'sh55555555) ^ i;
         op_backlog.push_back(it);
      end
      it = '{sbmq_pkg::OP_ENQ, 2'd1, 32'sh12345678};
      op_backlog.push_back(it);
      for (int i = 0; i < 6; i++) begin
         it.op = sbmq_pkg::OP_DEQ;
         it.qn = sbmq_pkg::QNUM_W'(i % sbmq_pkg::NUM_QUEUES_DEF);
         it.val = -32'sd1;
         op_backlog.push_back(it);
      end

      // Random phases vary the enqueue share between filling and draining the store.
      for (int p = 0; p < 10; p++) begin
         case (p % 5)
            0: enq_pct = 85;
            1: enq_pct = 15;
            2: enq_pct = 50;
            3: enq_pct = 70;
            default: enq_pct = 30;
         endcase
         for (int i = 0; i < 50; i++) begin
            it.op = ($urandom_range(0, 99) < enq_pct) ? sbmq_pkg::OP_ENQ : sbmq_pkg::OP_DEQ;
            it.qn = (p % 3 == 2 && $urandom_range(0, 1))
                    ? sbmq_pkg::QNUM_W'(p % sbmq_pkg::NUM_QUEUES_DEF)
                    : sbmq_pkg::QNUM_W'($urandom_range(0, 3));
            it.val = ($urandom_range(0, 15) == 0) ? edge_vals[$urandom_range(0, 3)]
                                                  : $urandom;
            op_backlog.push_back(it);
         end
      end
      total_items = op_backlog.size();
   end

   initial begin
      took_cnt = 0;
      got_cnt = 0;
      mismatch_cnt = 0;
      req_took = 1'b0;
      send_gap = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
            req_ch.valid <= 1'b0;
         end else if (op_backlog.size() != 0) begin
            next_op = op_backlog.pop_front();
            req_ch.opcode <= next_op.op;
            req_ch.queue_number <= next_op.qn;
            req_ch.value <= next_op.val;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // The long hold-off lets the sender keep offering transfers until the block stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && got_cnt >= 120) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 12) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : sample
      outcome_type due;
      op_item_type seen;
      if (reset) begin
         for (int i = 0; i < sbmq_pkg::SLOT_COUNT_DEF; i++) begin
            slot_word[i] = '0;
            slot_next[i] = SLOT_W'((i + 1) % sbmq_pkg::SLOT_COUNT_DEF);
         end
         for (int i = 0; i < sbmq_pkg::NUM_QUEUES_DEF; i++) begin
            q_first[i] = '0;
            q_last[i] = '0;
            q_vacant[i] = 1'b1;
         end
         spare_head = '0;
         spare_cnt = sbmq_pkg::SLOT_COUNT_DEF;
         req_took <= 1'b0;
      end else begin
         req_took <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_cnt <= got_cnt + 1;
            if (due_outcomes.size() == 0) begin
               flag_mismatch($sformatf("result with nothing pending, value %0d status %0d",
                                       rsp_ch.dequeued_value, rsp_ch.status));
            end else begin
               due = due_outcomes.pop_front();
               if (rsp_ch.dequeued_value !== due.word)
                  flag_mismatch($sformatf("dequeued_value %0d, wanted %0d",
                                          rsp_ch.dequeued_value, due.word));
               if (rsp_ch.status !== due.st)
                  flag_mismatch($sformatf("status %0d, wanted %0d", rsp_ch.status, due.st));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.op = sbmq_pkg::opcode_type'(req_ch.opcode);
            seen.qn = req_ch.queue_number;
            seen.val = req_ch.value;
            due_outcomes.push_back(queue_store_step(seen));
            took_cnt <= took_cnt + 1;
         end
      end
   end

   initial begin
      @(negedge reset);
      while (took_cnt < total_items || due_outcomes.size() != 0) @(negedge clock);
      repeat (6) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sbmq_pkg.sv
hw/rtl/sbmq_if.sv
hw/rtl/sbmq_ram.sv
hw/rtl/shared_buffer_multi_queue_top.sv
tb/tb_top.sv
